>>> hdl/plin_pkg.sv
// shared types and constants for the piecewise linear interpolator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package plin_pkg;

  // field widths that the item format fixes
  localparam int IDX_W    = 6;
  localparam int PC_W     = 7;
  localparam int TOL_W    = 8;
  localparam int STATUS_W = 2;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_MATCH_TOL   = 1'b1;

  // register reset values
  localparam logic [PC_W-1:0]  POINT_COUNT_RST = 7'd2;
  localparam logic [TOL_W-1:0] MATCH_TOL_RST   = 8'd1;

  // opcodes carried in the input tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 2'd2;

  // command queue
  localparam int Q_DEPTH = 2;

  // classification of one decoded item
  typedef struct packed {
    logic is_query;
    logic idx_ok;
  } cmd_ctl_t;

endpackage

>>> hdl/plin_front.sv
// front end: accepts input beats, decodes and classifies them into commands
// depends on plin_pkg
`timescale 1ns / 1ps

module plin_front import plin_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24,
  parameter int IN_DW       = 56
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DW-1:0]       s_tdata,
  input  logic                   s_tuser,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output cmd_ctl_t               cmd_ctl,
  output logic [IDX_W-1:0]       cmd_idx,
  output logic [VALUE_WIDTH-1:0] cmd_x,
  output logic [VALUE_WIDTH-1:0] cmd_y
);

  logic     hold_valid;
  cmd_ctl_t dec_ctl;

  // classify the incoming beat
  always_comb begin
    dec_ctl.is_query = (s_tuser == OP_QUERY);
    dec_ctl.idx_ok   = (int'(s_tdata[IDX_W-1:0]) < MAX_POINTS);
  end

  assign s_tready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_ctl <= dec_ctl;
      cmd_idx <= s_tdata[IDX_W-1:0];
      cmd_x   <= s_tdata[IDX_W +: VALUE_WIDTH];
      cmd_y   <= s_tdata[IDX_W+VALUE_WIDTH +: VALUE_WIDTH];
    end
  end

endmodule

>>> hdl/plin_fifo.sv
// short command queue between front end and engine
// depends on plin_pkg
`timescale 1ns / 1ps

module plin_fifo import plin_pkg::*; #(
  parameter int W = 54
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  cmd_ctl_t     push_ctl,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output cmd_ctl_t     pop_ctl,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_ctl_t       ctl_q [Q_DEPTH];
  logic [W-1:0]   dat_q [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_ctl    = ctl_q[rd_ptr];
  assign pop_data   = dat_q[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      priority if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wr_ptr] <= push_ctl;
      dat_q[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/plin_engine.sv
// back end: breakpoint tables, segment search, multiply, divide, result register
// depends on plin_pkg
`timescale 1ns / 1ps

module plin_engine import plin_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [PC_W-1:0]        point_count,
  input  logic [TOL_W-1:0]       match_tolerance,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_ctl_t               cmd_ctl,
  input  logic [IDX_W-1:0]       cmd_idx,
  input  logic [VALUE_WIDTH-1:0] cmd_x,
  input  logic [VALUE_WIDTH-1:0] cmd_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] y_out,
  output logic [STATUS_W-1:0]    status
);

  localparam int VW  = VALUE_WIDTH;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = VW + 1;
  localparam int PW  = 2 * DW;
  localparam int MCH = 16;
  localparam int MC  = (DW + MCH - 1) / MCH;
  localparam int MPW = MC * MCH;
  localparam int SCW = $clog2(DW + 1);
  localparam int CW  = VW + TOL_W + 1;
  localparam int SW  = VW + 3;

  localparam logic [VW-1:0] VMAX_V = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN_V = {1'b1, {(VW-1){1'b0}}};
  localparam logic [SW-1:0] VMAX_S = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [SW-1:0] VMIN_S = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SRCH   = 8'b0000_0010,
    S_DIFF   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DIVCHK = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_SUM    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  // breakpoint tables
  logic [VW-1:0] x_mem [MAX_POINTS];
  logic [VW-1:0] y_mem [MAX_POINTS];
  logic [VW-1:0] rd_x;
  logic [VW-1:0] rd_y;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // datapath registers
  logic [VW-1:0]       qx;
  logic [AW-1:0]       idx;
  logic [VW-1:0]       px;
  logic [VW-1:0]       py;
  logic [VW-1:0]       x1;
  logic [VW-1:0]       y1;
  logic [DW-1:0]       mag_a;
  logic [MPW-1:0]      mag_b;
  logic [DW-1:0]       mag_d;
  logic                neg;
  logic [PW-1:0]       prod;
  logic [DW-1:0]       rem;
  logic [DW-1:0]       dq;
  logic [DW-1:0]       quot;
  logic                ovf;
  logic [SCW-1:0]      step;
  logic [VW-1:0]       res_y;
  logic [STATUS_W-1:0] res_st;

  // combinational helpers
  logic [NW-1:0]        n_eff;
  logic                 last_idx;
  logic signed [CW-1:0] cmp_lhs;
  logic signed [CW-1:0] cmp_rhs;
  logic                 hit;
  logic signed [DW-1:0] den;
  logic signed [DW-1:0] dyv;
  logic signed [DW-1:0] dxv;
  logic [DW:0]          rem_sh;
  logic                 rem_ge;
  logic [SW-1:0]        ys;
  logic [SW-1:0]        qs;
  logic [SW-1:0]        sum;
  logic [DW+MCH-1:0]    pp;
  logic                 load_out;

  // points in use, clamped to the table depth
  always_comb begin
    if (int'(point_count) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count);
    end
  end

  assign last_idx = ((NW'(idx) + NW'(1)) == n_eff);

  // query against breakpoint x plus tolerance
  assign cmp_lhs = {{(CW-VW){qx[VW-1]}}, qx};
  assign cmp_rhs = {{(CW-VW){rd_x[VW-1]}}, rd_x} + {{(CW-TOL_W){1'b0}}, match_tolerance};
  assign hit     = (cmp_lhs <= cmp_rhs);

  // segment differences
  assign den = {x1[VW-1], x1} - {px[VW-1], px};
  assign dyv = {y1[VW-1], y1} - {py[VW-1], py};
  assign dxv = {qx[VW-1], qx} - {px[VW-1], px};

  // partial product of one multiplier digit
  assign pp = mag_a * mag_b[MPW-1 -: MCH];

  // one restoring division step
  assign rem_sh = {rem, dq[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, mag_d});

  // signed sum before saturation
  assign ys  = {{(SW-VW){py[VW-1]}}, py};
  assign qs  = {{(SW-DW){1'b0}}, quot};
  assign sum = neg ? ys - qs : ys + qs;

  assign cmd_ready = (state == S_IDLE);
  assign mem_we    = (state == S_IDLE) && cmd_valid && !cmd_ctl.is_query && cmd_ctl.idx_ok;
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  // read address runs one slot ahead of the compare
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = '0;
      S_SRCH:  rd_addr = idx + AW'(1);
      default: rd_addr = idx;
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[AW'(cmd_idx)] <= cmd_x;
      y_mem[AW'(cmd_idx)] <= cmd_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ctl.is_query) begin
            state <= (n_eff < NW'(2)) ? S_DONE : S_SRCH;
          end
        end
        S_SRCH: begin
          if (idx != '0) begin
            priority if (hit) begin
              state <= S_DIFF;
            end else if (last_idx) begin
              state <= S_DONE;
            end
          end
        end
        S_DIFF:   state <= (den == '0) ? S_DONE : S_MUL;
        S_MUL:    state <= (step == SCW'(MC - 1)) ? S_DIVCHK : S_MUL;
        S_DIVCHK: state <= (prod[PW-1 -: DW] >= mag_d) ? S_SUM : S_DIV;
        S_DIV:    state <= (step == SCW'(DW - 1)) ? S_SUM : S_DIV;
        S_SUM:    state <= S_DONE;
        S_DONE:   state <= load_out ? S_IDLE : S_DONE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        qx     <= cmd_x;
        idx    <= '0;
        res_y  <= '0;
        res_st <= ST_BEYOND;
      end
      S_SRCH: begin
        if (idx == '0 || !hit) begin
          px  <= rd_x;
          py  <= rd_y;
          idx <= idx + AW'(1);
        end else begin
          x1 <= rd_x;
          y1 <= rd_y;
        end
      end
      S_DIFF: begin
        res_y  <= '0;
        res_st <= ST_ZERO_WIDTH;
        mag_a  <= dxv[DW-1] ? DW'(-dxv) : DW'(dxv);
        mag_b  <= MPW'(dyv[DW-1] ? DW'(-dyv) : DW'(dyv));
        mag_d  <= den[DW-1] ? DW'(-den) : DW'(den);
        neg    <= dyv[DW-1] ^ dxv[DW-1] ^ den[DW-1];
        prod   <= '0;
        step   <= '0;
      end
      // multiply one 16-bit digit of the dy magnitude per cycle
      S_MUL: begin
        prod  <= (prod << MCH) + PW'(pp);
        mag_b <= mag_b << MCH;
        step  <= step + SCW'(1);
      end
      // quotient at or above 2^DW saturates the result
      S_DIVCHK: begin
        ovf  <= (prod[PW-1 -: DW] >= mag_d);
        rem  <= prod[PW-1 -: DW];
        dq   <= prod[DW-1:0];
        quot <= '0;
        step <= '0;
      end
      S_DIV: begin
        rem  <= rem_ge ? DW'(rem_sh - {1'b0, mag_d}) : rem_sh[DW-1:0];
        quot <= {quot[DW-2:0], rem_ge};
        dq   <= dq << 1;
        step <= step + SCW'(1);
      end
      S_SUM: begin
        res_st <= ST_OK;
        priority if (ovf) begin
          res_y <= neg ? VMIN_V : VMAX_V;
        end else if ($signed(sum) > $signed(VMAX_S)) begin
          res_y <= VMAX_V;
        end else if ($signed(sum) < $signed(VMIN_S)) begin
          res_y <= VMIN_V;
        end else begin
          res_y <= sum[VW-1:0];
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      y_out  <= res_y;
      status <= res_st;
    end
  end

endmodule

>>> hdl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator top level.
// Input stream: tuser is the opcode (load or query); tdata packs point_index,
// x_value and y_value. A load beat writes one breakpoint slot and returns
// nothing; a query beat returns one output beat with y_out and a status code.
// The APB port sets point_count (address 0) and match_tolerance (address 4);
// write them only while no item is in flight.
// A load writes its slot as the engine takes it. In a query the segment search
// reads one table slot per cycle through the single table read port, and the
// divider retires one quotient bit per cycle.
// Input beats are registered and queued two deep, so the front keeps taking
// beats while the engine works or waits, until register and queue are full.
// A result sits in the output register until m_axis_tready; while it waits,
// the engine holds the next result and stops popping the queue.
// Synchronous reset empties the pipeline and restores point_count to 2 and
// match_tolerance to 1; breakpoint tables are not cleared and must be loaded.
// depends on plin_pkg, plin_front, plin_fifo, plin_engine
`timescale 1ns / 1ps

module piecewise_linear_interpolator import plin_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int VALUE_WIDTH = 24
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // slave stream
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // tdata fields from bit 0: point_index, x_value, y_value, zero fill
  input  logic [((IDX_W+2*VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // tuser fields from bit 0: opcode
  input  logic                                          s_axis_tuser,
  // master stream
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // tdata fields from bit 0: y_out, zero fill
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]              m_axis_tdata,
  // tuser fields from bit 0: status
  output logic [STATUS_W-1:0]                           m_axis_tuser,
  // configuration
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [PADDR_W-1:0]                            paddr,
  input  logic [PDATA_W-1:0]                            pwdata,
  output logic [PDATA_W-1:0]                            prdata,
  output logic                                          pready
);

  localparam int IN_DW  = ((IDX_W + 2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DW = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int QW     = IDX_W + 2 * VALUE_WIDTH;

  logic [PC_W-1:0]        point_count;
  logic [TOL_W-1:0]       match_tolerance;
  logic                   cfg_we;

  logic                   f_valid;
  logic                   f_ready;
  cmd_ctl_t               f_ctl;
  logic [IDX_W-1:0]       f_idx;
  logic [VALUE_WIDTH-1:0] f_x;
  logic [VALUE_WIDTH-1:0] f_y;

  logic                   e_valid;
  logic                   e_ready;
  cmd_ctl_t               e_ctl;
  logic [QW-1:0]          e_data;

  logic [VALUE_WIDTH-1:0] y_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count     <= POINT_COUNT_RST;
      match_tolerance <= MATCH_TOL_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_POINT_COUNT: point_count     <= pwdata[PC_W-1:0];
        REG_MATCH_TOL:   match_tolerance <= pwdata[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POINT_COUNT: prdata = PDATA_W'(point_count);
      REG_MATCH_TOL:   prdata = PDATA_W'(match_tolerance);
      default:         prdata = '0;
    endcase
  end

  plin_front #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IN_DW       (IN_DW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_ctl   (f_ctl),
    .cmd_idx   (f_idx),
    .cmd_x     (f_x),
    .cmd_y     (f_y)
  );

  plin_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ctl   (f_ctl),
    .push_data  ({f_y, f_x, f_idx}),
    .pop_valid  (e_valid),
    .pop_ready  (e_ready),
    .pop_ctl    (e_ctl),
    .pop_data   (e_data)
  );

  plin_engine #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .point_count     (point_count),
    .match_tolerance (match_tolerance),
    .cmd_valid       (e_valid),
    .cmd_ready       (e_ready),
    .cmd_ctl         (e_ctl),
    .cmd_idx         (e_data[IDX_W-1:0]),
    .cmd_x           (e_data[IDX_W +: VALUE_WIDTH]),
    .cmd_y           (e_data[IDX_W+VALUE_WIDTH +: VALUE_WIDTH]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .y_out           (y_out),
    .status          (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DW'(y_out);

endmodule

>>> sim/tb_top.sv
// testbench for the piecewise linear interpolator: breakpoint loads and curve queries
// on the input stream, answers on the output stream, table size and tolerance over apb
// depends on plin_pkg and piecewise_linear_interpolator
`timescale 1ns / 1ps

module tb_top;
  import plin_pkg::*;

  localparam int NPTS      = 64;
  localparam int VW        = 24;
  localparam int QUIET_MAX = 4000;
  localparam int SETTLE    = 150;
  localparam logic [PADDR_W-1:0] PC_ADDR  = PADDR_W'({REG_POINT_COUNT, 2'b00});
  localparam logic [PADDR_W-1:0] TOL_ADDR = PADDR_W'({REG_MATCH_TOL, 2'b00});
  localparam longint VAL_MAX = 64'sd8388607;
  localparam longint VAL_MIN = -64'sd8388608;

  typedef struct {
    logic                 op;
    logic [IDX_W-1:0]     idx;
    logic signed [VW-1:0] xv;
    logic signed [VW-1:0] yv;
  } cmd_t;

  typedef struct {
    logic signed [VW-1:0] y;
    logic [STATUS_W-1:0]  st;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = OP_LOAD;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  piecewise_linear_interpolator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block: breakpoint tables and registers
  logic signed [VW-1:0] bp_x [NPTS];
  logic signed [VW-1:0] bp_y [NPTS];
  logic [PC_W-1:0]      cfg_points = POINT_COUNT_RST;
  logic [TOL_W-1:0]     cfg_tol    = MATCH_TOL_RST;

  cmd_t    cmd_backlog [$];
  answer_t answer_q [$];
  int      items_queued = 0;
  int      items_taken  = 0;
  int      answers_seen = 0;
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  logic    in_taken     = 1'b0;
  longint  curve_lo, curve_hi;

  // clock and reset
  always #4 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // interpolation on the shadow table for one query abscissa
  function automatic answer_t interp_predict(input logic signed [VW-1:0] xq);
    answer_t a;
    int      n, seg, i;
    longint  x0, x1, y0, y1, den, dy, dxq, quo, res;
    bit      neg;
    a.y  = '0;
    a.st = ST_BEYOND;
    n    = (cfg_points > NPTS) ? NPTS : int'(cfg_points);
    seg  = 0;
    for (i = 1; i < n; i++) begin
      if (seg == 0 && longint'(xq) <= longint'(bp_x[i]) + longint'(cfg_tol))
        seg = i;
    end
    if (seg == 0)
      return a;
    x0  = bp_x[seg-1];
    x1  = bp_x[seg];
    y0  = bp_y[seg-1];
    y1  = bp_y[seg];
    den = x1 - x0;
    if (den == 0) begin
      a.st = ST_ZERO_WIDTH;
      return a;
    end
    dy  = y1 - y0;
    dxq = longint'(xq) - x0;
    neg = ((dy < 0) != (dxq < 0)) != (den < 0);
    // magnitudes stay below 2^50, so the quotient fits easily
    quo = (mag(dy) * mag(dxq)) / mag(den);
    res = y0 + (neg ? -quo : quo);
    if (res > VAL_MAX)
      res = VAL_MAX;
    if (res < VAL_MIN)
      res = VAL_MIN;
    a.y  = res[VW-1:0];
    a.st = ST_OK;
    return a;
  endfunction

  // input driver
  always @(negedge clk) begin : drive_in
    cmd_t nxt;
    bit   drv_calm;
    drv_calm = (items_taken >= 300 && items_taken < 450);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (cmd_backlog.size() > 0 && (drv_calm || $urandom_range(0, 99) >= 25)) begin
        nxt = cmd_backlog.pop_front();
        s_axis_tdata  <= {2'b00, nxt.yv, nxt.xv, nxt.idx};
        s_axis_tuser  <= nxt.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready with random stalls
  always @(negedge clk) begin
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= (answers_seen >= 150 && answers_seen < 260) ||
                       ($urandom_range(0, 99) >= 25);
  end

  // monitor: prediction on accepted beats, checking, register shadow, watchdog
  always @(posedge clk) begin : monitor
    answer_t want;
    bit      busy;
    busy = 1'b0;
    in_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        if (paddr == PC_ADDR)
          cfg_points = pwdata[PC_W-1:0];
        else if (paddr == TOL_ADDR)
          cfg_tol = pwdata[TOL_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy = 1'b1;
        items_taken++;
        if (s_axis_tuser == OP_LOAD) begin
          bp_x[s_axis_tdata[5:0]] = s_axis_tdata[29:6];
          bp_y[s_axis_tdata[5:0]] = s_axis_tdata[53:30];
        end else begin
          answer_q.push_back(interp_predict(s_axis_tdata[29:6]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        answers_seen++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat, y_out %0d status %0d",
                   $time, $signed(m_axis_tdata[23:0]), m_axis_tuser);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (m_axis_tdata[23:0] !== want.y) begin
            $display("%0t: y_out mismatch, expected %0d actual %0d",
                     $time, want.y, $signed(m_axis_tdata[23:0]));
            mismatches++;
          end
          if (m_axis_tuser !== want.st) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.st, m_axis_tuser);
            mismatches++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_MAX);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic op, input int idx, input longint xv, input longint yv);
    cmd_t c;
    c.op  = op;
    c.idx = idx[IDX_W-1:0];
    c.xv  = xv[VW-1:0];
    c.yv  = yv[VW-1:0];
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  // every beat taken and every answer back, then let loads settle
  task automatic wait_drained();
    while (items_taken != items_queued || answer_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input int unsigned d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ascending breakpoints in slots 0 .. n-1, now and then a zero-width step
  task automatic load_curve(input int n);
    int     steps [NPTS];
    int     stepmax, i;
    longint total, xv, ycen;
    bit     wide_y;
    stepmax = $urandom_range(0, 1) ? (16777215 / ((n > 1) ? n - 1 : 1)) - 1 : 4000;
    wide_y  = $urandom_range(0, 1);
    total   = 0;
    for (i = 1; i < n; i++) begin
      steps[i] = ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, stepmax);
      total += steps[i];
    end
    xv       = VAL_MIN + $urandom_range(0, 16777215 - total);
    curve_lo = xv;
    ycen     = longint'($urandom_range(0, 200000)) - 100000;
    for (i = 0; i < n; i++) begin
      if (i > 0)
        xv += steps[i];
      if (wide_y)
        push_cmd(OP_LOAD, i, xv, longint'(signed'($urandom() & 32'h00ff_ffff) << 8) >>> 8);
      else
        push_cmd(OP_LOAD, i, xv, ycen + longint'($urandom_range(0, 20000)) - 10000);
    end
    curve_hi = xv;
  endtask

  // one register setting, a fresh curve, then mostly queries around it
  task automatic run_phase(input int pc, input int tol, input int count);
    int     n, r, k;
    longint margin, xv;
    wait_drained();
    apb_write(PC_ADDR, pc);
    apb_write(TOL_ADDR, tol);
    n = (pc > NPTS) ? NPTS : pc;
    load_curve(n);
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        margin = $urandom_range(0, 300);
        xv = curve_lo - margin + $urandom_range(0, curve_hi - curve_lo + 2 * margin);
        if (xv > VAL_MAX)
          xv = VAL_MAX;
        if (xv < VAL_MIN)
          xv = VAL_MIN;
        push_cmd(OP_QUERY, $urandom_range(0, 63), xv, $urandom());
      end else if (r < 85) begin
        push_cmd(OP_QUERY, $urandom_range(0, 63), $urandom(), $urandom());
      end else if (r < 90) begin
        // overwrite a live slot: table may lose its order
        push_cmd(OP_LOAD, $urandom_range(0, n - 1), $urandom(), $urandom());
      end else begin
        push_cmd(OP_LOAD, $urandom_range(0, 63), $urandom(), $urandom());
      end
    end
  endtask

  // stimulus
  initial begin
    // directed part under reset settings: two points, tolerance one
    push_cmd(OP_LOAD, 0, VAL_MIN, VAL_MIN);
    push_cmd(OP_LOAD, 1, VAL_MAX, VAL_MAX);
    push_cmd(OP_QUERY, 0, VAL_MIN, 0);
    push_cmd(OP_QUERY, 63, VAL_MAX, -1);
    push_cmd(OP_QUERY, 0, 0, 0);
    push_cmd(OP_LOAD, 63, VAL_MAX, VAL_MIN);
    // query just inside and just past the tolerance of the last point
    push_cmd(OP_LOAD, 1, 100, 500);
    push_cmd(OP_QUERY, 0, 101, 0);
    push_cmd(OP_QUERY, 0, 102, 0);
    // zero-width segment
    push_cmd(OP_LOAD, 1, VAL_MIN, 0);
    push_cmd(OP_QUERY, 0, VAL_MIN, 0);
    // steep slope: extrapolation before the first point and saturation both ways
    push_cmd(OP_LOAD, 0, 0, 0);
    push_cmd(OP_LOAD, 1, 1, VAL_MAX);
    push_cmd(OP_QUERY, 0, -1000, 0);
    push_cmd(OP_QUERY, 0, 2, 0);
    // fractional quotients truncate toward zero
    push_cmd(OP_LOAD, 1, 3, -10);
    push_cmd(OP_QUERY, 0, 1, 0);
    push_cmd(OP_QUERY, 0, -1, 0);
    // unordered table, negative segment width
    push_cmd(OP_LOAD, 0, 1000, 0);
    push_cmd(OP_LOAD, 1, -1000, 5000);
    push_cmd(OP_QUERY, 0, -2000, 0);
    push_cmd(OP_QUERY, 0, -999, 0);
    push_cmd(OP_QUERY, 0, VAL_MAX, 0);

    // random phases over several register settings
    run_phase(1, 0, 60);
    run_phase(64, 255, 220);
    run_phase(100, 0, 200);
    run_phase(5, 128, 180);
    run_phase(2, 0, 140);
    run_phase(3, 255, 140);
    run_phase($urandom_range(2, 64), $urandom_range(0, 255), 220);

    wait_drained();
    if (mismatches == 0 && answer_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
